// ----- rtl/core/qxm_pkg.sv -----
package qxm_pkg;

    localparam int CMD_W   = 16;
    localparam int STICK_W = 12;
    localparam int CFG_W   = 12;
    localparam int FACT_W  = 9;
    localparam int MOTOR_W = 14;
    localparam int KIND_W  = 2;
    localparam int IDX_W   = 2;

    // internal widths, sized to the value ranges
    localparam int CLAMP_W = 11;   // +/-1000
    localparam int RANGE_W = 13;   // pwm_max - pwm_min
    localparam int PROD_W  = 24;   // clamped cmd * range
    localparam int BASE_W  = 26;   // stick * range + pwm_min * 4096
    localparam int TPROD_W = 36;   // base * thr_gain
    localparam int MAG_W   = 22;   // |cmd * range|
    localparam int RECIP_W = 23;
    localparam int QUO_W   = 12;   // |term|
    localparam int TERM_W  = 13;
    localparam int THR_W   = 15;
    localparam int MIX_W   = 15;
    localparam int SUM_W   = 16;   // thr + mix
    localparam int ADJ_W   = 17;   // adjusted throttle
    localparam int FIN_W   = 18;   // adjusted throttle + mix
    localparam int THR_FRAC = 20;
    localparam int RECIP_SHIFT = 32;

    localparam logic signed [CLAMP_W-1:0] CMD_LIMIT = 11'sd1000;
    // ceil(2^32 / 1000): exact floor division for magnitudes below 2^22
    localparam logic [RECIP_W-1:0] RECIP_1000 = 23'd4294968;
    localparam logic signed [TPROD_W-1:0] THR_HALF = 36'sd524288;

    localparam logic signed [MOTOR_W-1:0] MOTOR_HI = 14'sd8191;
    localparam logic signed [MOTOR_W-1:0] MOTOR_LO = -14'sd8192;

    localparam logic [IDX_W-1:0] REG_PWM_MIN    = 2'd0;
    localparam logic [IDX_W-1:0] REG_PWM_MAX    = 2'd1;
    localparam logic [IDX_W-1:0] REG_IDLE_STICK = 2'd2;
    localparam logic [IDX_W-1:0] REG_THR_GAIN   = 2'd3;

    localparam logic [CFG_W-1:0]  PWM_MIN_RST    = 12'd100;
    localparam logic [CFG_W-1:0]  PWM_MAX_RST    = 12'd1000;
    localparam logic [CFG_W-1:0]  IDLE_STICK_RST = 12'd410;
    localparam logic [FACT_W-1:0] THR_GAIN_RST   = 9'd230;

    localparam logic [KIND_W-1:0] KIND_KEEP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RAISE = 2'd2;

    typedef struct packed {
        logic [CFG_W-1:0]  pwm_min;
        logic [CFG_W-1:0]  pwm_max;
        logic [CFG_W-1:0]  idle_stick;
        logic [FACT_W-1:0] thr_gain;
    } cfg_t;

    typedef struct packed {
        logic                      armed;
        logic signed [PROD_W-1:0]  p_prod;
        logic signed [PROD_W-1:0]  r_prod;
        logic signed [PROD_W-1:0]  y_prod;
        logic signed [BASE_W-1:0]  thr_base;
    } front_t;

endpackage

// ----- rtl/core/quad_x_motor_mixer.sv -----
// channel   direction  handshake                  payload
// s_        in         s_valid / s_ready          pitch, roll, yaw, stick, armed
// m_        out        m_valid / m_ready          four motor commands, desat kind
// cfg_      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One sample per cycle sustained while the m_ side accepts; a result passes through
// one front register, the queue and four back stages (multiply, round and mix,
// extremes, final sum).
// Synchronous active-low reset restores the register defaults and empties all stages.
// A stalled m_ side fills the back stages, then the queue, then holds s_ready low.
// cfg_ready is always high.
module quad_x_motor_mixer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [qxm_pkg::CMD_W-1:0]       s_pitch_cmd,
    input  logic signed [qxm_pkg::CMD_W-1:0]       s_roll_cmd,
    input  logic signed [qxm_pkg::CMD_W-1:0]       s_yaw_cmd,
    input  logic [qxm_pkg::STICK_W-1:0]            s_throttle_stick,
    input  logic                                   s_armed,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_front_a,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_front_b,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_rear_a,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_rear_b,
    output logic [qxm_pkg::KIND_W-1:0]             m_desat_kind,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qxm_pkg::IDX_W-1:0]              cfg_index,
    input  logic [qxm_pkg::CFG_W-1:0]              cfg_data
);

    qxm_pkg::cfg_t    cfg_reg;
    logic             f_valid, f_ready;
    qxm_pkg::front_t  f_data;
    logic             q_valid, q_ready;
    qxm_pkg::front_t  q_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pwm_min    <= qxm_pkg::PWM_MIN_RST;
            cfg_reg.pwm_max    <= qxm_pkg::PWM_MAX_RST;
            cfg_reg.idle_stick <= qxm_pkg::IDLE_STICK_RST;
            cfg_reg.thr_gain   <= qxm_pkg::THR_GAIN_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                qxm_pkg::REG_PWM_MIN: begin
                    cfg_reg.pwm_min <= cfg_data;
                end
                qxm_pkg::REG_PWM_MAX: begin
                    cfg_reg.pwm_max <= cfg_data;
                end
                qxm_pkg::REG_IDLE_STICK: begin
                    cfg_reg.idle_stick <= cfg_data;
                end
                qxm_pkg::REG_THR_GAIN: begin
                    cfg_reg.thr_gain <= cfg_data[qxm_pkg::FACT_W-1:0];
                end
            endcase
        end
    end

    qxm_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pitch_cmd      (s_pitch_cmd),
        .s_roll_cmd       (s_roll_cmd),
        .s_yaw_cmd        (s_yaw_cmd),
        .s_throttle_stick (s_throttle_stick),
        .s_armed          (s_armed),
        .f_valid          (f_valid),
        .f_ready          (f_ready),
        .f_data           (f_data)
    );

    qxm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    qxm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .in_valid        (q_valid),
        .in_ready        (q_ready),
        .in_data         (q_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_motor_front_a (m_motor_front_a),
        .m_motor_front_b (m_motor_front_b),
        .m_motor_rear_a  (m_motor_rear_a),
        .m_motor_rear_b  (m_motor_rear_b),
        .m_desat_kind    (m_desat_kind)
    );

endmodule

// ----- rtl/core/qxm_front.sv -----
module qxm_front (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  qxm_pkg::cfg_t                          cfg,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [qxm_pkg::CMD_W-1:0]       s_pitch_cmd,
    input  logic signed [qxm_pkg::CMD_W-1:0]       s_roll_cmd,
    input  logic signed [qxm_pkg::CMD_W-1:0]       s_yaw_cmd,
    input  logic [qxm_pkg::STICK_W-1:0]            s_throttle_stick,
    input  logic                                   s_armed,
    output logic                                   f_valid,
    input  logic                                   f_ready,
    output qxm_pkg::front_t                        f_data
);

    function automatic logic signed [qxm_pkg::CLAMP_W-1:0] clamp_cmd(
        input logic signed [qxm_pkg::CMD_W-1:0] c
    );
        logic signed [qxm_pkg::CLAMP_W-1:0] r;
        if (c > qxm_pkg::CMD_W'(qxm_pkg::CMD_LIMIT)) begin
            r = qxm_pkg::CMD_LIMIT;
        end else if (c < -qxm_pkg::CMD_W'(qxm_pkg::CMD_LIMIT)) begin
            r = -qxm_pkg::CMD_LIMIT;
        end else begin
            r = c[qxm_pkg::CLAMP_W-1:0];
        end
        return r;
    endfunction

    logic                                  f_valid_reg;
    qxm_pkg::front_t                       f_data_reg;
    qxm_pkg::front_t                       f_data_next;
    logic                                  load;
    logic                                  active;
    logic signed [qxm_pkg::RANGE_W-1:0]    range;
    logic signed [qxm_pkg::CLAMP_W-1:0]    pc, rc, yc;

    assign s_ready = !f_valid_reg || f_ready;
    assign load    = s_valid && s_ready;
    assign f_valid = f_valid_reg;
    assign f_data  = f_data_reg;

    always_comb begin
        range  = $signed({1'b0, cfg.pwm_max}) - $signed({1'b0, cfg.pwm_min});
        active = s_throttle_stick >= cfg.idle_stick;
        pc     = clamp_cmd(s_pitch_cmd);
        rc     = clamp_cmd(s_roll_cmd);
        yc     = clamp_cmd(s_yaw_cmd);
        f_data_next.armed  = s_armed;
        // below idle stick the attitude terms drop out
        f_data_next.p_prod = active ? qxm_pkg::PROD_W'(pc * range) : '0;
        f_data_next.r_prod = active ? qxm_pkg::PROD_W'(rc * range) : '0;
        f_data_next.y_prod = active ? qxm_pkg::PROD_W'(yc * range) : '0;
        f_data_next.thr_base =
            qxm_pkg::BASE_W'($signed({1'b0, s_throttle_stick}) * range)
            + $signed({2'b00, cfg.pwm_min, 12'b0});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (s_ready) begin
            f_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            f_data_reg <= f_data_next;
        end
    end

endmodule

// ----- rtl/core/qxm_fifo.sv -----
module qxm_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  qxm_pkg::front_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output qxm_pkg::front_t  out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qxm_pkg::front_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                push, pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not grow on transfer in");

    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not shrink on transfer out");

endmodule

// ----- rtl/core/qxm_back.sv -----
module qxm_back (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  qxm_pkg::cfg_t                          cfg,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  qxm_pkg::front_t                        in_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_front_a,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_front_b,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_rear_a,
    output logic signed [qxm_pkg::MOTOR_W-1:0]     m_motor_rear_b,
    output logic [qxm_pkg::KIND_W-1:0]             m_desat_kind
);

    // |x| / 1000 by reciprocal multiply, exact for |x| < 2^22
    function automatic logic [qxm_pkg::QUO_W-1:0] div1000(
        input logic signed [qxm_pkg::PROD_W-1:0] x
    );
        logic [qxm_pkg::PROD_W-1:0]                  a;
        logic [qxm_pkg::MAG_W+qxm_pkg::RECIP_W-1:0]  prod;
        a    = x[qxm_pkg::PROD_W-1] ? qxm_pkg::PROD_W'(-x) : qxm_pkg::PROD_W'(x);
        prod = a[qxm_pkg::MAG_W-1:0] * qxm_pkg::RECIP_1000;
        return prod[qxm_pkg::RECIP_SHIFT +: qxm_pkg::QUO_W];
    endfunction

    function automatic logic signed [qxm_pkg::TERM_W-1:0] apply_sign(
        input logic [qxm_pkg::QUO_W-1:0] q,
        input logic                      neg
    );
        logic signed [qxm_pkg::TERM_W-1:0] t;
        t = $signed({1'b0, q});
        return neg ? -t : t;
    endfunction

    function automatic logic signed [qxm_pkg::MOTOR_W-1:0] sat_motor(
        input logic signed [qxm_pkg::FIN_W-1:0] v
    );
        logic signed [qxm_pkg::MOTOR_W-1:0] r;
        if (v > qxm_pkg::FIN_W'(qxm_pkg::MOTOR_HI)) begin
            r = qxm_pkg::MOTOR_HI;
        end else if (v < qxm_pkg::FIN_W'(qxm_pkg::MOTOR_LO)) begin
            r = qxm_pkg::MOTOR_LO;
        end else begin
            r = v[qxm_pkg::MOTOR_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [qxm_pkg::SUM_W-1:0] smax(
        input logic signed [qxm_pkg::SUM_W-1:0] a,
        input logic signed [qxm_pkg::SUM_W-1:0] b
    );
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [qxm_pkg::SUM_W-1:0] smin(
        input logic signed [qxm_pkg::SUM_W-1:0] a,
        input logic signed [qxm_pkg::SUM_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

    logic en1, en2, en3, en4;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;

    // stage 1: throttle product and term quotients
    logic signed [qxm_pkg::TPROD_W-1:0]  s1_tprod_reg, s1_tprod_next;
    logic [qxm_pkg::QUO_W-1:0]           s1_quo_reg [3];
    logic [qxm_pkg::QUO_W-1:0]           s1_quo_next [3];
    logic [2:0]                          s1_neg_reg, s1_neg_next;
    logic                                s1_armed_reg;

    // stage 2: rounded throttle and the X mix
    logic signed [qxm_pkg::TPROD_W-1:0]  rnd;
    logic signed [qxm_pkg::TERM_W-1:0]   tp, tr, ty;
    logic signed [qxm_pkg::MIX_W-1:0]    ep, er, ey;
    logic signed [qxm_pkg::THR_W-1:0]    s2_thr_reg, s2_thr_next;
    logic signed [qxm_pkg::MIX_W-1:0]    s2_mix_reg [4];
    logic signed [qxm_pkg::MIX_W-1:0]    s2_mix_next [4];
    logic                                s2_armed_reg;

    // stage 3: extremes and throttle correction
    logic signed [qxm_pkg::SUM_W-1:0]    msum [4];
    logic signed [qxm_pkg::SUM_W-1:0]    mx, mn;
    logic signed [qxm_pkg::ADJ_W-1:0]    s3_adj_reg, s3_adj_next;
    logic signed [qxm_pkg::MIX_W-1:0]    s3_mix_reg [4];
    logic [qxm_pkg::KIND_W-1:0]          s3_kind_reg, s3_kind_next;
    logic [qxm_pkg::CFG_W-1:0]           s3_lim_reg, s3_lim_next;
    logic                                s3_armed_reg;

    // stage 4: output register
    logic signed [qxm_pkg::MOTOR_W-1:0]  s4_motor_reg [4];
    logic signed [qxm_pkg::MOTOR_W-1:0]  s4_motor_next [4];
    logic [qxm_pkg::KIND_W-1:0]          s4_kind_reg, s4_kind_next;
    logic [qxm_pkg::CFG_W-1:0]           s4_lim_reg;

    assign en4      = !s4_valid_reg || m_ready;
    assign en3      = !s3_valid_reg || en4;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    assign m_valid         = s4_valid_reg;
    assign m_motor_front_a = s4_motor_reg[0];
    assign m_motor_front_b = s4_motor_reg[1];
    assign m_motor_rear_a  = s4_motor_reg[2];
    assign m_motor_rear_b  = s4_motor_reg[3];
    assign m_desat_kind    = s4_kind_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            if (en1) begin
                s1_valid_reg <= in_valid;
            end
            if (en2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4) begin
                s4_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_comb begin
        s1_tprod_next = qxm_pkg::TPROD_W'(in_data.thr_base
                                          * $signed({1'b0, cfg.thr_gain}));
        s1_quo_next[0] = div1000(in_data.p_prod);
        s1_quo_next[1] = div1000(in_data.r_prod);
        s1_quo_next[2] = div1000(in_data.y_prod);
        s1_neg_next    = {in_data.y_prod[qxm_pkg::PROD_W-1],
                          in_data.r_prod[qxm_pkg::PROD_W-1],
                          in_data.p_prod[qxm_pkg::PROD_W-1]};
    end

    always_ff @(posedge aclk) begin
        if (en1 && in_valid) begin
            s1_tprod_reg <= s1_tprod_next;
            s1_quo_reg   <= s1_quo_next;
            s1_neg_reg   <= s1_neg_next;
            s1_armed_reg <= in_data.armed;
        end
    end

    always_comb begin
        // round half up, then floor shift
        rnd         = s1_tprod_reg + qxm_pkg::THR_HALF;
        s2_thr_next = rnd[qxm_pkg::THR_FRAC +: qxm_pkg::THR_W];
        tp = apply_sign(s1_quo_reg[0], s1_neg_reg[0]);
        tr = apply_sign(s1_quo_reg[1], s1_neg_reg[1]);
        ty = apply_sign(s1_quo_reg[2], s1_neg_reg[2]);
        ep = qxm_pkg::MIX_W'(tp);
        er = qxm_pkg::MIX_W'(tr);
        ey = qxm_pkg::MIX_W'(ty);
        s2_mix_next[0] =  ep + er + ey;
        s2_mix_next[1] = -ep + er - ey;
        s2_mix_next[2] = -ep - er + ey;
        s2_mix_next[3] =  ep - er - ey;
    end

    always_ff @(posedge aclk) begin
        if (en2 && s1_valid_reg) begin
            s2_thr_reg   <= s2_thr_next;
            s2_mix_reg   <= s2_mix_next;
            s2_armed_reg <= s1_armed_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            msum[i] = qxm_pkg::SUM_W'(s2_thr_reg) + qxm_pkg::SUM_W'(s2_mix_reg[i]);
        end
        mx = smax(smax(msum[0], msum[1]), smax(msum[2], msum[3]));
        mn = smin(smin(msum[0], msum[1]), smin(msum[2], msum[3]));
        // the high limit wins; the low limit is checked only when no overshoot
        priority if (mx > $signed({4'b0000, cfg.pwm_max})) begin
            s3_adj_next  = qxm_pkg::ADJ_W'(s2_thr_reg) - qxm_pkg::ADJ_W'(mx)
                           + $signed({5'b00000, cfg.pwm_max});
            s3_kind_next = qxm_pkg::KIND_LOWER;
            s3_lim_next  = cfg.pwm_max;
        end else if (mn < $signed({4'b0000, cfg.pwm_min})) begin
            s3_adj_next  = qxm_pkg::ADJ_W'(s2_thr_reg) - qxm_pkg::ADJ_W'(mn)
                           + $signed({5'b00000, cfg.pwm_min});
            s3_kind_next = qxm_pkg::KIND_RAISE;
            s3_lim_next  = cfg.pwm_min;
        end else begin
            s3_adj_next  = qxm_pkg::ADJ_W'(s2_thr_reg);
            s3_kind_next = qxm_pkg::KIND_KEEP;
            s3_lim_next  = cfg.pwm_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && s2_valid_reg) begin
            s3_adj_reg   <= s3_adj_next;
            s3_mix_reg   <= s2_mix_reg;
            s3_kind_reg  <= s3_kind_next;
            s3_lim_reg   <= s3_lim_next;
            s3_armed_reg <= s2_armed_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            s4_motor_next[i] = s3_armed_reg
                ? sat_motor(qxm_pkg::FIN_W'(s3_adj_reg) + qxm_pkg::FIN_W'(s3_mix_reg[i]))
                : '0;
        end
        s4_kind_next = s3_armed_reg ? s3_kind_reg : qxm_pkg::KIND_KEEP;
    end

    always_ff @(posedge aclk) begin
        if (en4 && s3_valid_reg) begin
            s4_motor_reg <= s4_motor_next;
            s4_kind_reg  <= s4_kind_next;
            s4_lim_reg   <= s3_lim_reg;
        end
    end

    // after lowering, the highest motor sits exactly on pwm_max
    a_lower_hits_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_desat_kind == qxm_pkg::KIND_LOWER |->
            s4_motor_reg[0] == $signed({2'b00, s4_lim_reg})
            || s4_motor_reg[1] == $signed({2'b00, s4_lim_reg})
            || s4_motor_reg[2] == $signed({2'b00, s4_lim_reg})
            || s4_motor_reg[3] == $signed({2'b00, s4_lim_reg}))
        else $error("lowered throttle does not put a motor on the high limit");

    // after raising, the lowest motor sits exactly on pwm_min
    a_raise_hits_min: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_desat_kind == qxm_pkg::KIND_RAISE |->
            s4_motor_reg[0] == $signed({2'b00, s4_lim_reg})
            || s4_motor_reg[1] == $signed({2'b00, s4_lim_reg})
            || s4_motor_reg[2] == $signed({2'b00, s4_lim_reg})
            || s4_motor_reg[3] == $signed({2'b00, s4_lim_reg}))
        else $error("raised throttle does not put a motor on the low limit");

endmodule

// ----- bench/quad_x_motor_mixer_tb.sv -----
module quad_x_motor_mixer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import qxm_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 220;
    localparam int N_PHASES    = 8;
    localparam int N_PLAN      = 21;
    localparam int STICK_MAX   = (1 << STICK_W) - 1;
    localparam int CFG_MAX     = (1 << CFG_W) - 1;

    typedef struct packed {
        logic signed [CMD_W-1:0] pitch;
        logic signed [CMD_W-1:0] roll;
        logic signed [CMD_W-1:0] yaw;
        logic [STICK_W-1:0]      stick;
        logic                    armed;
    } sample_t;

    typedef struct packed {
        logic signed [MOTOR_W-1:0] front_a;
        logic signed [MOTOR_W-1:0] front_b;
        logic signed [MOTOR_W-1:0] rear_a;
        logic signed [MOTOR_W-1:0] rear_b;
        logic [KIND_W-1:0]         kind;
    } motors_t;

    typedef struct packed {
        sample_t smp;
        logic    known;
        motors_t want;
    } plan_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic signed [CMD_W-1:0]   s_pitch_cmd = '0;
    logic signed [CMD_W-1:0]   s_roll_cmd = '0;
    logic signed [CMD_W-1:0]   s_yaw_cmd = '0;
    logic [STICK_W-1:0]        s_throttle_stick = '0;
    logic                      s_armed = 1'b0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [MOTOR_W-1:0] m_motor_front_a;
    logic signed [MOTOR_W-1:0] m_motor_front_b;
    logic signed [MOTOR_W-1:0] m_motor_rear_a;
    logic signed [MOTOR_W-1:0] m_motor_rear_b;
    logic [KIND_W-1:0]         m_desat_kind;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [IDX_W-1:0]          cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;

    quad_x_motor_mixer dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // register image as the block should hold it
    cfg_t ctl = '{PWM_MIN_RST, PWM_MAX_RST, IDLE_STICK_RST, THR_GAIN_RST};

    motors_t pending_motors[$];
    bit src_gaps = 1'b1;
    bit snk_gaps = 1'b1;
    int mismatches = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_disarmed = 0;
    int n_lowered = 0;
    int n_raised = 0;
    int n_settings = 0;
    int quiet = 0;

    // typed-in results assume the register defaults
    plan_row_t plan [N_PLAN] = '{
        '{'{16'sd0, 16'sd0, 16'sd0, 12'd0, 1'b0}, 1'b1,
          '{14'sd0, 14'sd0, 14'sd0, 14'sd0, KIND_KEEP}},
        '{'{16'sh7FFF, 16'sh8000, 16'sh7FFF, 12'hFFF, 1'b0}, 1'b1,
          '{14'sd0, 14'sd0, 14'sd0, 14'sd0, KIND_KEEP}},
        '{'{16'sd0, 16'sd0, 16'sd0, 12'd0, 1'b1}, 1'b1,
          '{14'sd100, 14'sd100, 14'sd100, 14'sd100, KIND_RAISE}},
        '{'{16'sd0, 16'sd0, 16'sd0, 12'hFFF, 1'b1}, 1'b1,
          '{14'sd898, 14'sd898, 14'sd898, 14'sd898, KIND_KEEP}},
        '{'{16'sh7FFF, 16'sd0, 16'sd0, 12'hFFF, 1'b1}, 1'b1,
          '{14'sd1000, -14'sd800, -14'sd800, 14'sd1000, KIND_LOWER}},
        '{'{16'sh8000, 16'sd0, 16'sd0, 12'hFFF, 1'b1}, 1'b1,
          '{-14'sd800, 14'sd1000, 14'sd1000, -14'sd800, KIND_LOWER}},
        '{'{16'sd0, 16'sh7FFF, 16'sd0, 12'hFFF, 1'b1}, 1'b0, '0},
        '{'{16'sd0, 16'sh8000, 16'sd0, 12'hFFF, 1'b1}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sh7FFF, 12'hFFF, 1'b1}, 1'b0, '0},
        '{'{16'sd0, 16'sd0, 16'sh8000, 12'hFFF, 1'b1}, 1'b0, '0},
        '{'{16'sd1000, 16'sd1000, 16'sd1000, 12'd2048, 1'b1}, 1'b0, '0},
        '{'{-16'sd1000, -16'sd1000, -16'sd1000, 12'd2048, 1'b1}, 1'b0, '0},
        '{'{16'sd1001, -16'sd1001, 16'sd999, 12'd2048, 1'b1}, 1'b0, '0},
        '{'{16'sd500, 16'sd300, -16'sd200, 12'd409, 1'b1}, 1'b0, '0},
        '{'{16'sd500, 16'sd300, -16'sd200, 12'd410, 1'b1}, 1'b0, '0},
        '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 12'd0, 1'b1}, 1'b0, '0},
        '{'{16'sd1, -16'sd1, 16'sd1, 12'd3000, 1'b1}, 1'b0, '0},
        '{'{-16'sd7, 16'sd13, -16'sd999, 12'd1500, 1'b1}, 1'b0, '0},
        '{'{16'sd200, -16'sd150, 16'sd50, 12'd2048, 1'b1}, 1'b0, '0},
        '{'{16'sh5555, 16'shAAAA, 16'sh5555, 12'hAAA, 1'b1}, 1'b0, '0},
        '{'{16'shAAAA, 16'sh5555, 16'shAAAA, 12'h555, 1'b1}, 1'b0, '0}
    };

    function automatic longint attitude_term(input logic signed [CMD_W-1:0] cmd,
                                             input longint span);
        longint c;
        c = longint'(cmd);
        if (c > longint'(CMD_LIMIT))
            c = longint'(CMD_LIMIT);
        else if (c < -longint'(CMD_LIMIT))
            c = -longint'(CMD_LIMIT);
        return c * span / longint'(CMD_LIMIT);
    endfunction

    function automatic logic signed [MOTOR_W-1:0] sat_motor(input longint v);
        if (v > longint'(MOTOR_HI))
            return MOTOR_HI;
        if (v < longint'(MOTOR_LO))
            return MOTOR_LO;
        return v[MOTOR_W-1:0];
    endfunction

    function automatic motors_t mix_motors(input sample_t smp);
        motors_t res;
        longint span, thr, p, r, y, top, bot;
        longint mix [4];
        res = '0;
        if (!smp.armed)
            return res;
        span = longint'(ctl.pwm_max) - longint'(ctl.pwm_min);
        thr = (longint'(smp.stick) * span + (longint'(ctl.pwm_min) <<< STICK_W))
              * longint'(ctl.thr_gain);
        // round half up, floor for negatives
        thr = (thr + longint'(THR_HALF)) >>> THR_FRAC;
        p = 0;
        r = 0;
        y = 0;
        if (smp.stick >= ctl.idle_stick) begin
            p = attitude_term(smp.pitch, span);
            r = attitude_term(smp.roll, span);
            y = attitude_term(smp.yaw, span);
        end
        mix[0] = p + r + y;
        mix[1] = -p + r - y;
        mix[2] = -p - r + y;
        mix[3] = p - r - y;
        top = thr + mix[0];
        bot = top;
        for (int i = 1; i < 4; i++) begin
            if (thr + mix[i] > top)
                top = thr + mix[i];
            if (thr + mix[i] < bot)
                bot = thr + mix[i];
        end
        res.kind = KIND_KEEP;
        if (top > longint'(ctl.pwm_max)) begin
            thr -= top - longint'(ctl.pwm_max);
            res.kind = KIND_LOWER;
        end else if (bot < longint'(ctl.pwm_min)) begin
            thr -= bot - longint'(ctl.pwm_min);
            res.kind = KIND_RAISE;
        end
        res.front_a = sat_motor(thr + mix[0]);
        res.front_b = sat_motor(thr + mix[1]);
        res.rear_a  = sat_motor(thr + mix[2]);
        res.rear_b  = sat_motor(thr + mix[3]);
        return res;
    endfunction

    function automatic logic signed [CMD_W-1:0] rand_cmd();
        int v;
        case ($urandom_range(0, 9))
            0: v = $urandom;
            1: v = $urandom_range(0, 1) ? 32767 : -32768;
            2: begin
                // around the clamp point
                v = 995 + int'($urandom_range(0, 10));
                if ($urandom_range(0, 1))
                    v = -v;
            end
            default: v = int'($urandom_range(0, 2400)) - 1200;
        endcase
        return v[CMD_W-1:0];
    endfunction

    function automatic sample_t rand_sample();
        sample_t smp;
        int lvl;
        smp.pitch = rand_cmd();
        smp.roll  = rand_cmd();
        smp.yaw   = rand_cmd();
        case ($urandom_range(0, 5))
            0: lvl = int'(ctl.idle_stick) + int'($urandom_range(0, 8)) - 4;
            1: lvl = $urandom_range(0, 1) ? STICK_MAX : 0;
            default: lvl = $urandom_range(0, STICK_MAX);
        endcase
        if (lvl < 0)
            lvl = 0;
        if (lvl > STICK_MAX)
            lvl = STICK_MAX;
        smp.stick = lvl[STICK_W-1:0];
        smp.armed = $urandom_range(0, 7) != 0;
        return smp;
    endfunction

    task automatic send_sample(input sample_t smp, input motors_t want);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_pitch_cmd      <= smp.pitch;
        s_roll_cmd       <= smp.roll;
        s_yaw_cmd        <= smp.yaw;
        s_throttle_stick <= smp.stick;
        s_armed          <= smp.armed;
        do @(posedge aclk); while (!s_ready);
        pending_motors.push_back(want);
        n_sent++;
        if (!smp.armed)
            n_disarmed++;
    endtask

    // stop sending and wait for the pipeline to empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_motors.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] vals [4]);
        logic [IDX_W-1:0] order [4];
        order = '{REG_PWM_MIN, REG_PWM_MAX, REG_IDLE_STICK, REG_THR_GAIN};
        for (int i = 0; i < 4; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= order[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (order[i])
                REG_PWM_MIN:    ctl.pwm_min = vals[i];
                REG_PWM_MAX:    ctl.pwm_max = vals[i];
                REG_IDLE_STICK: ctl.idle_stick = vals[i];
                REG_THR_GAIN:   ctl.thr_gain = vals[i][FACT_W-1:0];
            endcase
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    task automatic check_result(input motors_t got);
        motors_t want;
        if (pending_motors.size() == 0) begin
            mismatches++;
            $display("%0t: result with no sample pending, expected none, %s",
                     $time, "actual:");
            $display("    %0d %0d %0d %0d kind %0d",
                     got.front_a, got.front_b, got.rear_a, got.rear_b, got.kind);
        end else begin
            want = pending_motors.pop_front();
            n_checked++;
            case (want.kind)
                KIND_LOWER: n_lowered++;
                KIND_RAISE: n_raised++;
                default: ;
            endcase
            compare_field("motor_front_a", int'($signed(want.front_a)),
                          int'($signed(got.front_a)));
            compare_field("motor_front_b", int'($signed(want.front_b)),
                          int'($signed(got.front_b)));
            compare_field("motor_rear_a", int'($signed(want.rear_a)),
                          int'($signed(got.rear_a)));
            compare_field("motor_rear_b", int'($signed(want.rear_b)),
                          int'($signed(got.rear_b)));
            compare_field("desat_kind", int'(want.kind), int'(got.kind));
        end
    endtask

    initial begin : result_sink
        motors_t got;
        int stall;
        wait (aresetn);
        forever begin
            stall = snk_gaps ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got = '{m_motor_front_a, m_motor_front_b, m_motor_rear_a, m_motor_rear_b,
                    m_desat_kind};
            check_result(got);
        end
    end

    // cycles without any transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, quiet, pending_motors.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] vals [4];
        sample_t smp;
        int pause_at;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i])
            send_sample(plan[i].smp,
                        plan[i].known ? plan[i].want : mix_motors(plan[i].smp));

        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: vals = '{PWM_MIN_RST, PWM_MAX_RST, IDLE_STICK_RST,
                            CFG_W'(THR_GAIN_RST)};
                1: vals = '{12'd0, 12'd4095, 12'd0, 12'd256};
                2: vals = '{12'd4095, 12'd0, 12'd4095, 12'hFFF};
                3: vals = '{12'd0, 12'd0, 12'd0, 12'd0};
                4: vals = '{12'd4095, 12'd4095, 12'd4095, 12'd1};
                5: vals = '{12'd2000, 12'd1000, 12'd2048, 12'd300};
                6: begin
                    vals[0] = CFG_W'($urandom_range(0, 1500));
                    vals[1] = vals[0] + CFG_W'($urandom_range(100, 2500));
                    vals[2] = CFG_W'($urandom_range(0, CFG_MAX));
                    vals[3] = CFG_W'($urandom_range(0, 256));
                end
                default: begin
                    foreach (vals[i])
                        vals[i] = CFG_W'($urandom_range(0, CFG_MAX));
                end
            endcase
            load_settings(vals);
            pause_at = $urandom_range(20, PHASE_ITEMS - 20);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k % 40 == 0) begin
                    src_gaps = $urandom_range(0, 2) != 0;
                    snk_gaps = $urandom_range(0, 2) != 0;
                end
                if (k == pause_at)
                    settle();
                smp = rand_sample();
                send_sample(smp, mix_motors(smp));
            end
        end

        settle();
        repeat (12) @(posedge aclk);
        $display("%0d samples sent (%0d disarmed), %0d results checked",
                 n_sent, n_disarmed, n_checked);
        $display("over %0d register settings; throttle lowered %0d, raised %0d, %0d mismatches",
                 n_settings, n_lowered, n_raised, mismatches);
        if (mismatches == 0 && pending_motors.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
